### hdl/sot_pkg.sv
package sot_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

   localparam int ADDR_WIDTH = 4;
   localparam int DATA_WIDTH = 32;

   localparam logic [1:0] REG_BIT_DELAY    = 2'd0;
   localparam logic [1:0] REG_PACKET_DELAY = 2'd1;
   localparam logic [1:0] REG_LEAD_DELAY   = 2'd2;
   localparam logic [1:0] REG_REPEAT_COUNT = 2'd3;

   localparam logic [15:0] BIT_DELAY_RESET    = 16'd84;
   localparam logic [15:0] PACKET_DELAY_RESET = 16'd1000;
   localparam logic [7:0]  LEAD_DELAY_RESET   = 8'd10;
   localparam logic [3:0]  REPEAT_COUNT_RESET = 4'd3;

   localparam logic [15:0] PREAMBLE = 16'hF000;
   localparam logic [3:0]  LAST_BIT = 4'd15;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_LEAD = 3'd1;
   localparam logic [2:0] PH_HIGH = 3'd2;
   localparam logic [2:0] PH_LOW  = 3'd3;
   localparam logic [2:0] PH_GAP  = 3'd4;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   function automatic count_type sat_count(input logic [15:0] v);
      logic [32:0] ext;
      ext = {17'd0, v};
      if (ext > COUNT_MAX) begin
         return COUNT_MAX[COUNT_WIDTH-1:0];
      end
      return ext[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic [15:0] encode_word(input logic [6:0] data);
      logic [15:0] w;
      logic c4, c3, c2, c1, c0;
      w  = PREAMBLE | {4'd0, data, 5'd0};
      c4 = w[11] ^ w[10] ^ w[9];
      c3 = w[8] ^ w[7] ^ w[6];
      c2 = w[11] ^ w[10] ^ w[8] ^ w[7] ^ w[5];
      c1 = w[11] ^ w[9] ^ w[8] ^ w[6] ^ w[5];
      c0 = (^w[11:5]) ^ c4 ^ c3 ^ c2 ^ c1;
      return {w[15:5], c4, c3, c2, c1, c0};
   endfunction

endpackage

### hdl/sot_if.sv
interface sot_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [6:0] payload;

   modport source (output valid, output op, output payload, input ready);
   modport sink (input valid, input op, input payload, output ready);
endinterface

interface sot_rsp_if;
   logic        valid;
   logic        ready;
   logic        tx_level;
   logic        busy_res;
   logic        frame_done;
   logic        start_rejected;
   logic [15:0] encoded_word;

   modport source (output valid, output tx_level, output busy_res, output frame_done,
                   output start_rejected, output encoded_word, input ready);
   modport sink (input valid, input tx_level, input busy_res, input frame_done,
                 input start_rejected, input encoded_word, output ready);
endinterface

### hdl/secded_ook_packet_transmitter.sv
// Channel  Direction  Fields
// req_ch   in         op, payload
// rsp_ch   out        tx_level, busy_res, frame_done, start_rejected, encoded_word
// csr      APB        bit_delay, packet_delay, lead_delay, repeat_count
//
// One item is accepted per clock while the result register is empty or being drained.
// Reset is synchronous and returns the registers to their defaults and the sequencer to idle.
// A stalled result holds req_ch.ready low until it is taken.
module secded_ook_packet_transmitter (
   input  logic                            clock,
   input  logic                            reset,
   sot_req_if.sink                         req_ch,
   sot_rsp_if.source                       rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sot_pkg::ADDR_WIDTH-1:0]  paddr,
   input  logic [sot_pkg::DATA_WIDTH-1:0]  pwdata,
   output logic [sot_pkg::DATA_WIDTH-1:0]  prdata,
   output logic                            pready
);

   logic [15:0] bit_delay_ff;
   logic [15:0] packet_delay_ff;
   logic [7:0]  lead_delay_ff;
   logic [3:0]  repeat_count_ff;

   logic [2:0]           phase_ff, phase_in;
   sot_pkg::count_type   count_ff, count_in;
   logic [3:0]           bit_index_ff, bit_index_in;
   logic [3:0]           packet_count_ff, packet_count_in;
   logic [15:0]          word_ff, word_in;

   logic        rsp_valid_ff;
   logic        level_ff, level_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        rej_ff, rej_in;
   logic [15:0] word_out_ff;

   logic               accept;
   logic               csr_write;
   logic               busy_now;
   logic               cur_level;
   logic               gap_end;
   logic [3:0]         reps;
   logic [3:0]         pc_next;
   sot_pkg::count_type bit_len;
   sot_pkg::count_type lead_len;
   sot_pkg::count_type gap_len;
   sot_pkg::count_type count_dec;
   logic [2:0]         lead_phase;
   sot_pkg::count_type lead_cnt;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_delay_ff    <= sot_pkg::BIT_DELAY_RESET;
         packet_delay_ff <= sot_pkg::PACKET_DELAY_RESET;
         lead_delay_ff   <= sot_pkg::LEAD_DELAY_RESET;
         repeat_count_ff <= sot_pkg::REPEAT_COUNT_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            sot_pkg::REG_BIT_DELAY: begin
               bit_delay_ff <= pwdata[15:0];
            end
            sot_pkg::REG_PACKET_DELAY: begin
               packet_delay_ff <= pwdata[15:0];
            end
            sot_pkg::REG_LEAD_DELAY: begin
               lead_delay_ff <= pwdata[7:0];
            end
            sot_pkg::REG_REPEAT_COUNT: begin
               repeat_count_ff <= pwdata[3:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         sot_pkg::REG_BIT_DELAY:    prdata = {16'd0, bit_delay_ff};
         sot_pkg::REG_PACKET_DELAY: prdata = {16'd0, packet_delay_ff};
         sot_pkg::REG_LEAD_DELAY:   prdata = {24'd0, lead_delay_ff};
         sot_pkg::REG_REPEAT_COUNT: prdata = {28'd0, repeat_count_ff};
         default:                   prdata = '0;
      endcase
   end

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign bit_len    = sot_pkg::sat_count((bit_delay_ff == 16'd0) ? 16'd1 : bit_delay_ff);
   assign lead_len   = sot_pkg::sat_count({8'd0, lead_delay_ff});
   assign gap_len    = sot_pkg::sat_count(packet_delay_ff);
   assign reps       = (repeat_count_ff == 4'd0) ? 4'd1 : repeat_count_ff;
   assign lead_phase = (lead_len == '0) ? sot_pkg::PH_HIGH : sot_pkg::PH_LEAD;
   assign lead_cnt   = (lead_len == '0) ? bit_len : lead_len;
   assign busy_now   = (phase_ff >= sot_pkg::PH_LEAD) && (phase_ff <= sot_pkg::PH_GAP);
   assign cur_level  = (phase_ff == sot_pkg::PH_HIGH) && word_ff[bit_index_ff];
   assign count_dec  = (count_ff != '0) ? count_ff - 1'b1 : count_ff;
   assign pc_next    = packet_count_ff + 4'd1;

   always_comb begin
      phase_in        = phase_ff;
      count_in        = count_ff;
      bit_index_in    = bit_index_ff;
      packet_count_in = packet_count_ff;
      word_in         = word_ff;
      level_in        = 1'b0;
      busy_in         = 1'b0;
      done_in         = 1'b0;
      rej_in          = 1'b0;
      gap_end         = 1'b0;
      if (req_ch.op) begin
         busy_in = 1'b1;
         if (busy_now) begin
            rej_in   = 1'b1;
            level_in = cur_level;
         end else begin
            word_in         = sot_pkg::encode_word(req_ch.payload);
            bit_index_in    = sot_pkg::LAST_BIT;
            packet_count_in = 4'd0;
            phase_in        = lead_phase;
            count_in        = lead_cnt;
            level_in        = (lead_phase == sot_pkg::PH_HIGH) && word_in[sot_pkg::LAST_BIT];
         end
      end else if (busy_now) begin
         busy_in  = 1'b1;
         level_in = cur_level;
         count_in = count_dec;
         if (count_dec == '0) begin
            case (phase_ff)
               sot_pkg::PH_LEAD: begin
                  phase_in = sot_pkg::PH_HIGH;
                  count_in = bit_len;
               end
               sot_pkg::PH_HIGH: begin
                  phase_in = sot_pkg::PH_LOW;
                  count_in = bit_len;
               end
               sot_pkg::PH_LOW: begin
                  if (bit_index_ff != 4'd0) begin
                     bit_index_in = bit_index_ff - 4'd1;
                     phase_in     = lead_phase;
                     count_in     = lead_cnt;
                  end else begin
                     phase_in = sot_pkg::PH_GAP;
                     count_in = gap_len;
                     gap_end  = (gap_len == '0);
                  end
               end
               sot_pkg::PH_GAP: begin
                  gap_end = 1'b1;
               end
               default: begin
               end
            endcase
            if (gap_end) begin
               packet_count_in = pc_next;
               bit_index_in    = sot_pkg::LAST_BIT;
               if (pc_next >= reps) begin
                  phase_in = sot_pkg::PH_IDLE;
                  count_in = '0;
                  done_in  = 1'b1;
               end else begin
                  phase_in = lead_phase;
                  count_in = lead_cnt;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= sot_pkg::PH_IDLE;
         count_ff        <= '0;
         bit_index_ff    <= sot_pkg::LAST_BIT;
         packet_count_ff <= 4'd0;
         word_ff         <= 16'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff        <= phase_in;
            count_ff        <= count_in;
            bit_index_ff    <= bit_index_in;
            packet_count_ff <= packet_count_in;
            word_ff         <= word_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         level_ff    <= level_in;
         busy_ff     <= busy_in;
         done_ff     <= done_in;
         rej_ff      <= rej_in;
         word_out_ff <= word_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.tx_level       = level_ff;
   assign rsp_ch.busy_res       = busy_ff;
   assign rsp_ch.frame_done     = done_ff;
   assign rsp_ch.start_rejected = rej_ff;
   assign rsp_ch.encoded_word   = word_out_ff;

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> busy_ff)
      else $error("frame_done without busy_res");

   a_rej_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rej_ff || level_ff) |-> busy_ff)
      else $error("rejected start or high level while not busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      accept && done_in |=> phase_ff == sot_pkg::PH_IDLE)
      else $error("sequencer not idle after frame end");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("item accepted while result stalled");

endmodule
